/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// property checked only outside reset (active low reset)
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/eab_pkg.sv */
package eab_pkg;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // internal fixed point is q2.30
  localparam int          IQ        = 30;
  localparam logic [31:0] ONE_Q     = 32'h4000_0000;
  localparam logic [31:0] HALF_Q    = 32'h2000_0000;
  localparam logic [30:0] HALF_PI_Q = 31'd1686629713;

  // horner divisors of the quarter-wave series
  localparam int SIN_STEPS = 6;
  localparam int COS_STEPS = 7;
  localparam int SIN_K [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};
  localparam int COS_K [COS_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

  // sine/cosine unit: range, square, three stages per horner step, quadrant fold
  localparam int SC_LAT  = 3 + 3 * COS_STEPS;
  // products, second products, sums, output rounding
  localparam int LATENCY = SC_LAT + 4;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } sm_t;

  typedef struct packed {
    sm_t sn;
    sm_t cs;
  } sc_t;

endpackage

/* rtl/eab_sincos.sv */
module eab_sincos #(
  parameter int ANGLE_BITS = eab_pkg::ANGLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [eab_pkg::IN_W-1:0] in_angle,
  output logic                     out_vld,
  output eab_pkg::sc_t             out_sc
);
  import eab_pkg::*;

  localparam int RW = ANGLE_BITS - 2;
  localparam logic [RW+30:0] XRND = (RW + 31)'(1) << (RW - 1);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  logic [ANGLE_BITS-1:0] ang;
  logic [RW+30:0]        xprod;
  logic [30:0]           x1_nxt;
  logic [30:0]           x1_r;
  logic [1:0]            q1_r;
  logic                  v1_r;
  logic [61:0]           sq;

  // step boundaries
  logic [31:0] x2_r  [0:COS_STEPS-1];
  logic [30:0] x_r   [0:COS_STEPS-1];
  logic [1:0]  q_r   [0:COS_STEPS];
  logic        vld_r [0:COS_STEPS];
  logic [31:0] tc_r  [1:COS_STEPS];
  logic [31:0] ts_r  [1:COS_STEPS];

  sc_t  sc_nxt;
  sc_t  sc_r;
  logic sc_vld_r;

  assign ang    = ANGLE_BITS'(in_angle);
  // angle remainder scaled to radians, rounded
  assign xprod  = (RW + 31)'(ang[RW-1:0]) * (RW + 31)'(HALF_PI_Q) + XRND;
  assign x1_nxt = xprod[RW+30:RW];

  always_ff @(posedge clk) begin
    x1_r <= x1_nxt;
    q1_r <= ang[ANGLE_BITS-1 -: 2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      v1_r     <= in_vld;
      vld_r[0] <= v1_r;
    end
  end

  assign sq = 62'(x1_r) * 62'(x1_r) + 62'(HALF_Q);

  always_ff @(posedge clk) begin
    x2_r[0] <= sq[61:30];
    x_r[0]  <= x1_r;
    q_r[0]  <= q1_r;
  end

  for (genvar j = 0; j < COS_STEPS; j++) begin : g_step
    localparam int          KC = COS_K[j];
    localparam logic [31:0] MC = 32'((64'd1 << 32) / 64'(KC));

    logic [31:0] tc_in;
    logic [31:0] ts_in;
    logic [63:0] pc;
    logic [63:0] mc;
    logic [39:0] kc;
    logic [39:0] rc;
    logic [32:0] dc;
    logic [31:0] vc_a_r;
    logic [31:0] qc_b_r;
    logic [31:0] vc_b_r;
    logic [1:0]  q_a_r;
    logic [1:0]  q_b_r;
    logic        vld_a_r;
    logic        vld_b_r;

    if (j == 0) begin : g_first
      assign tc_in = ONE_Q;
      assign ts_in = ONE_Q;
    end else begin : g_next
      assign tc_in = tc_r[j];
      assign ts_in = ts_r[j];
    end

    // cosine: t <- 1 - round(x2 * t) / k, floored at zero
    assign pc = 64'(x2_r[j]) * 64'(tc_in) + 64'(HALF_Q);
    assign mc = 64'(vc_a_r) * 64'(MC);
    assign kc = 40'(qc_b_r) * 40'(KC);
    assign rc = 40'(vc_b_r) - kc;
    assign dc = 33'(qc_b_r) + 33'(rc >= 40'(KC));

    always_ff @(posedge clk) begin
      vc_a_r     <= pc[61:30];
      qc_b_r     <= mc[63:32];
      vc_b_r     <= vc_a_r;
      tc_r[j+1]  <= (dc >= 33'(ONE_Q)) ? 32'd0 : 32'(33'(ONE_Q) - dc);
      q_a_r      <= q_r[j];
      q_b_r      <= q_a_r;
      q_r[j+1]   <= q_b_r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_a_r    <= 1'b0;
        vld_b_r    <= 1'b0;
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_a_r    <= vld_r[j];
        vld_b_r    <= vld_a_r;
        vld_r[j+1] <= vld_b_r;
      end
    end

    if (j < COS_STEPS - 1) begin : g_carry
      logic [31:0] x2_a_r;
      logic [31:0] x2_b_r;
      logic [30:0] x_a_r;
      logic [30:0] x_b_r;

      always_ff @(posedge clk) begin
        x2_a_r    <= x2_r[j];
        x2_b_r    <= x2_a_r;
        x2_r[j+1] <= x2_b_r;
        x_a_r     <= x_r[j];
        x_b_r     <= x_a_r;
        x_r[j+1]  <= x_b_r;
      end
    end

    if (j < SIN_STEPS) begin : g_sin
      localparam int          KS = SIN_K[j];
      localparam logic [31:0] MS = 32'((64'd1 << 32) / 64'(KS));

      logic [63:0] ps;
      logic [63:0] ms;
      logic [39:0] ks;
      logic [39:0] rs;
      logic [32:0] ds;
      logic [31:0] vs_a_r;
      logic [31:0] qs_b_r;
      logic [31:0] vs_b_r;

      assign ps = 64'(x2_r[j]) * 64'(ts_in) + 64'(HALF_Q);
      assign ms = 64'(vs_a_r) * 64'(MS);
      assign ks = 40'(qs_b_r) * 40'(KS);
      assign rs = 40'(vs_b_r) - ks;
      assign ds = 33'(qs_b_r) + 33'(rs >= 40'(KS));

      always_ff @(posedge clk) begin
        vs_a_r    <= ps[61:30];
        qs_b_r    <= ms[63:32];
        vs_b_r    <= vs_a_r;
        ts_r[j+1] <= (ds >= 33'(ONE_Q)) ? 32'd0 : 32'(33'(ONE_Q) - ds);
      end
    end else begin : g_sin_fin
      // sine = round(x * t), then two alignment stages
      logic [63:0] ps;
      logic [31:0] s_a_r;
      logic [31:0] s_b_r;

      assign ps = 64'(x_r[j]) * 64'(ts_in) + 64'(HALF_Q);

      always_ff @(posedge clk) begin
        s_a_r     <= ps[61:30];
        s_b_r     <= s_a_r;
        ts_r[j+1] <= s_b_r;
      end
    end
  end

  // quadrant fold
  always_comb begin
    case (q_r[COS_STEPS])
      QUAD_I: begin
        sc_nxt.sn = '{neg: 1'b0, mag: ts_r[COS_STEPS]};
        sc_nxt.cs = '{neg: 1'b0, mag: tc_r[COS_STEPS]};
      end
      QUAD_II: begin
        sc_nxt.sn = '{neg: 1'b0, mag: tc_r[COS_STEPS]};
        sc_nxt.cs = '{neg: 1'b1, mag: ts_r[COS_STEPS]};
      end
      QUAD_III: begin
        sc_nxt.sn = '{neg: 1'b1, mag: ts_r[COS_STEPS]};
        sc_nxt.cs = '{neg: 1'b1, mag: tc_r[COS_STEPS]};
      end
      QUAD_IV: begin
        sc_nxt.sn = '{neg: 1'b1, mag: tc_r[COS_STEPS]};
        sc_nxt.cs = '{neg: 1'b0, mag: ts_r[COS_STEPS]};
      end
      default: begin
        sc_nxt.sn = '{neg: 1'b0, mag: ts_r[COS_STEPS]};
        sc_nxt.cs = '{neg: 1'b0, mag: tc_r[COS_STEPS]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sc_r <= sc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else begin
      sc_vld_r <= vld_r[COS_STEPS];
    end
  end

  assign out_sc  = sc_r;
  assign out_vld = sc_vld_r;

endmodule

/* rtl/euler_angles_to_basis_vectors.sv */
// euler angles to forward / right / up basis vectors
//
// input channel: drive pitch, yaw and roll binary angles (full turn is
//   2^ANGLE_BITS) with start high; the item is taken at any edge where start
//   is high and busy is low. busy stays low, so an item may enter every cycle
// result channel: out_valid is high for exactly one cycle with the nine
//   q1.FRAC_BITS components of forward, right and up on the out_ ports
// pipeline: each sine/cosine unit registers angle scaling, the square, seven
//   chained cosine horner steps of three stages each with the sine steps and
//   the final sine product beside them, then the quadrant fold; after them come
//   first products, second products, signed sums and output rounding
// throughput: one item per cycle, no gaps, fully pipelined
// reset: synchronous, active low; clears every valid bit in the pipeline, so
//   items in flight are dropped and nothing comes out until new items arrive
// the receiver cannot stall: every result is shown once and must be taken
module euler_angles_to_basis_vectors #(
  parameter int FRAC_BITS  = eab_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = eab_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [eab_pkg::IN_W-1:0]         in_pitch_angle,
  input  logic [eab_pkg::IN_W-1:0]         in_yaw_angle,
  input  logic [eab_pkg::IN_W-1:0]         in_roll_angle,
  output logic                             out_valid,
  output logic signed [eab_pkg::OUT_W-1:0] out_forward_x,
  output logic signed [eab_pkg::OUT_W-1:0] out_forward_y,
  output logic signed [eab_pkg::OUT_W-1:0] out_forward_z,
  output logic signed [eab_pkg::OUT_W-1:0] out_right_x,
  output logic signed [eab_pkg::OUT_W-1:0] out_right_y,
  output logic signed [eab_pkg::OUT_W-1:0] out_right_z,
  output logic signed [eab_pkg::OUT_W-1:0] out_up_x,
  output logic signed [eab_pkg::OUT_W-1:0] out_up_y,
  output logic signed [eab_pkg::OUT_W-1:0] out_up_z
);
  import eab_pkg::*;

  // output rounding from q2.30 to q1.FRAC_BITS
  localparam int          SH  = IQ - FRAC_BITS;
  localparam logic [35:0] RND = (SH > 0) ? (36'd1 << (SH - 1)) : 36'd0;
  localparam logic [35:0] LIM = 36'd1 << FRAC_BITS;

  // signed product of two q2.30 values, ties away from zero
  function automatic sm_t smul(sm_t a, sm_t b);
    logic [63:0] p;
    sm_t         res;
    p       = 64'(a.mag) * 64'(b.mag) + 64'(HALF_Q);
    res.neg = a.neg ^ b.neg;
    res.mag = p[61:30];
    return res;
  endfunction

  function automatic logic signed [34:0] to_s(sm_t a);
    logic signed [34:0] m;
    m = $signed({3'b000, a.mag});
    return a.neg ? -m : m;
  endfunction

  // round to nearest (ties away from zero), saturate to +/- 1.0
  function automatic logic [OUT_W-1:0] to_out(logic signed [34:0] v);
    logic        neg;
    logic [35:0] mag;
    logic [35:0] rmag;
    logic [35:0] sat;
    logic [35:0] res;
    neg  = v[34];
    mag  = neg ? 36'(-v) : 36'(v);
    rmag = (mag + RND) >> SH;
    sat  = (rmag > LIM) ? LIM : rmag;
    res  = neg ? -sat : sat;
    return res[OUT_W-1:0];
  endfunction

  logic in_vld;
  logic vld_p, vld_y, vld_r0;
  sc_t  sc_p, sc_y, sc_r;
  logic sc_vld;

  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  // one sine/cosine unit per angle, all in lockstep
  eab_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .in_angle(in_pitch_angle),
    .out_vld(vld_p), .out_sc(sc_p)
  );

  eab_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .in_angle(in_yaw_angle),
    .out_vld(vld_y), .out_sc(sc_y)
  );

  eab_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .in_angle(in_roll_angle),
    .out_vld(vld_r0), .out_sc(sc_r)
  );

  assign sc_vld = vld_p & vld_y & vld_r0;

  // stage 1: first-level products
  sm_t  spcy_r, spsy_r, cpcy_r, cpsy_r, srcp_r, crcp_r;
  sm_t  crsy_r, srsy_r, srcy_r, crcy_r;
  sm_t  sp1_r, sr1_r, cr1_r;
  logic v1_r;

  always_ff @(posedge clk) begin
    spcy_r <= smul(sc_p.sn, sc_y.cs);
    spsy_r <= smul(sc_p.sn, sc_y.sn);
    cpcy_r <= smul(sc_p.cs, sc_y.cs);
    cpsy_r <= smul(sc_p.cs, sc_y.sn);
    srcp_r <= smul(sc_r.sn, sc_p.cs);
    crcp_r <= smul(sc_r.cs, sc_p.cs);
    crsy_r <= smul(sc_r.cs, sc_y.sn);
    srsy_r <= smul(sc_r.sn, sc_y.sn);
    srcy_r <= smul(sc_r.sn, sc_y.cs);
    crcy_r <= smul(sc_r.cs, sc_y.cs);
    sp1_r  <= sc_p.sn;
    sr1_r  <= sc_r.sn;
    cr1_r  <= sc_r.cs;
  end

  // stage 2: roll times the pitch/yaw products, carry the rest
  sm_t  a1_r, a2_r, b1_r, b2_r;
  sm_t  cpcy2_r, cpsy2_r, sp2_r, srcp2_r, crcp2_r;
  sm_t  crsy2_r, srsy2_r, srcy2_r, crcy2_r;
  logic v2_r;

  always_ff @(posedge clk) begin
    a1_r    <= smul(sr1_r, spcy_r);
    a2_r    <= smul(sr1_r, spsy_r);
    b1_r    <= smul(cr1_r, spcy_r);
    b2_r    <= smul(cr1_r, spsy_r);
    cpcy2_r <= cpcy_r;
    cpsy2_r <= cpsy_r;
    sp2_r   <= sp1_r;
    srcp2_r <= srcp_r;
    crcp2_r <= crcp_r;
    crsy2_r <= crsy_r;
    srsy2_r <= srsy_r;
    srcy2_r <= srcy_r;
    crcy2_r <= crcy_r;
  end

  // stage 3: signed sums
  logic signed [34:0] fx_r, fy_r, fz_r, rx_r, ry_r, rz_r, ux_r, uy_r, uz_r;
  logic               v3_r;

  always_ff @(posedge clk) begin
    fx_r <= to_s(cpcy2_r);
    fy_r <= to_s(cpsy2_r);
    fz_r <= -to_s(sp2_r);
    rx_r <= to_s(a1_r) - to_s(crsy2_r);
    ry_r <= to_s(a2_r) + to_s(crcy2_r);
    rz_r <= to_s(srcp2_r);
    ux_r <= to_s(b1_r) + to_s(srsy2_r);
    uy_r <= to_s(b2_r) - to_s(srcy2_r);
    uz_r <= to_s(crcp2_r);
  end

  // stage 4: output rounding and saturation
  logic [OUT_W-1:0] ofx_r, ofy_r, ofz_r, orx_r, ory_r, orz_r, oux_r, ouy_r, ouz_r;
  logic             v4_r;

  always_ff @(posedge clk) begin
    ofx_r <= to_out(fx_r);
    ofy_r <= to_out(fy_r);
    ofz_r <= to_out(fz_r);
    orx_r <= to_out(rx_r);
    ory_r <= to_out(ry_r);
    orz_r <= to_out(rz_r);
    oux_r <= to_out(ux_r);
    ouy_r <= to_out(uy_r);
    ouz_r <= to_out(uz_r);
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= sc_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid     = v4_r;
  assign out_forward_x = $signed(ofx_r);
  assign out_forward_y = $signed(ofy_r);
  assign out_forward_z = $signed(ofz_r);
  assign out_right_x   = $signed(orx_r);
  assign out_right_y   = $signed(ory_r);
  assign out_right_z   = $signed(orz_r);
  assign out_up_x      = $signed(oux_r);
  assign out_up_y      = $signed(ouy_r);
  assign out_up_z      = $signed(ouz_r);

endmodule

/* rtl/eab_checker.sv */
`include "assert_macros.svh"

module eab_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic [eab_pkg::IN_W-1:0]         in_pitch_angle,
  input logic [eab_pkg::IN_W-1:0]         in_roll_angle,
  input logic                             out_valid,
  input logic signed [eab_pkg::OUT_W-1:0] out_forward_z,
  input logic signed [eab_pkg::OUT_W-1:0] out_right_z
);
  import eab_pkg::*;

  logic acc;
  assign acc = start && !busy;

  // the block never refuses an item
  `ASSERT_CLK(a_never_busy, clk, !busy, "busy raised")

  // every result comes from an item taken a fixed latency earlier
  `ASSERT_RST(a_out_has_item, clk, rst_n, out_valid |-> $past(acc, LATENCY), "result without item")

  // zero pitch gives a level forward vector
  `ASSERT_RST(a_pitch_zero, clk, rst_n, out_valid && $past(acc && in_pitch_angle == '0, LATENCY) |-> out_forward_z == '0, "forward_z not zero for zero pitch")

  // zero roll keeps the right vector horizontal
  `ASSERT_RST(a_roll_zero, clk, rst_n, out_valid && $past(acc && in_roll_angle == '0, LATENCY) |-> out_right_z == '0, "right_z not zero for zero roll")

endmodule

bind euler_angles_to_basis_vectors eab_checker u_eab_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_pitch_angle(in_pitch_angle),
  .in_roll_angle(in_roll_angle),
  .out_valid(out_valid),
  .out_forward_z(out_forward_z),
  .out_right_z(out_right_z)
);
